// ===== rtl/ebcpu_pkg.sv =====
`default_nettype none
package ebcpu_pkg;
    localparam int ADDR_BITS_DEF = 16;
    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_EXEC = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    typedef struct packed {
        logic [15:0] pc;
        logic [7:0]  acc;
        logic [15:0] bc;
        logic [15:0] de;
        logic [15:0] hl;
        logic        fz;
        logic        fs;
        logic        fp;
        logic        fa;
        logic        fc;
    } cpu_state_t;

    typedef struct packed {
        logic        we;
        logic [15:0] addr;
        logic [7:0]  wdata;
    } mem_req_t;

    function automatic logic even_par(input logic [7:0] v);
        return ~^v;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/ebcpu_mem.sv =====
`default_nettype none
module ebcpu_mem #(
    parameter int ADDR_BITS = ebcpu_pkg::ADDR_BITS_DEF
) (
    input  wire                 clk,
    input  ebcpu_pkg::mem_req_t req,
    output logic [7:0]          rdata
);
    import ebcpu_pkg::*;
    logic [7:0] mem [0:(1 << ADDR_BITS) - 1];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr[ADDR_BITS-1:0]] <= req.wdata;
        end
        rdata <= mem[req.addr[ADDR_BITS-1:0]];
    end
endmodule
`default_nettype wire

// ===== rtl/eight_bit_cpu_subset_executor_core.sv =====
`default_nettype none
// channel | dir | tdata fields (low bit up)
// s_axis  | in  | mode[1:0], addr[17:2], wdata[25:18], pad to 32
// m_axis  | out | pc, acc, pair_bc, pair_de, pair_hl, zero, sign, parity, aux, carry,
//         |     | read_byte (85 bits used, zero-padded to 104)
// Load: write from idle; read: address from idle, byte taken in S_RD; execute: opcode fetch,
// up to two operand fetches or one data access, on the single memory port.
// Reset clears registers, PC and flags; memory is not cleared.
// Input is taken only when the output register is empty.
module eight_bit_cpu_subset_executor_core #(
    parameter int ADDR_BITS = ebcpu_pkg::ADDR_BITS_DEF
) (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [31:0]  s_axis_tdata,   // mode, addr, wdata
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [103:0] m_axis_tdata    // pc,acc,bc,de,hl,z,s,p,ac,cy,read_byte
);
    import ebcpu_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_OP   = 3'd1;
    localparam logic [2:0] S_LO   = 3'd2;
    localparam logic [2:0] S_HI   = 3'd3;
    localparam logic [2:0] S_DATA = 3'd4;
    localparam logic [2:0] S_RD   = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0] st_reg, st_next;
    cpu_state_t cs_reg, cs_next;
    logic [7:0] op_reg, op_next, lo_reg, lo_next, rb_reg, rb_next;
    logic       ov_reg, ov_next;
    mem_req_t   req;
    logic [7:0] rdata;

    ebcpu_mem #(.ADDR_BITS(ADDR_BITS)) u_mem (.clk(clk), .req(req), .rdata(rdata));

    logic [1:0]  in_mode;
    logic [15:0] in_addr;
    logic [7:0]  in_wdata;
    assign in_mode  = s_axis_tdata[1:0];
    assign in_addr  = s_axis_tdata[17:2];
    assign in_wdata = s_axis_tdata[25:18];
    assign s_axis_tready = (st_reg == S_IDLE) && !ov_reg;
    assign m_axis_tvalid = ov_reg;

    logic [15:0] pr_val, pc1;
    logic [7:0]  r_val, inr_v, dcr_v;
    logic [16:0] dad;
    assign pc1 = cs_reg.pc + 16'd1;
    always_comb
    begin
        case (op_reg[5:4])
            2'd0:    pr_val = cs_reg.bc;
            2'd1:    pr_val = cs_reg.de;
            default: pr_val = cs_reg.hl;
        endcase
        case (op_reg[4:3])
            2'd0:    r_val = cs_reg.bc[15:8];
            2'd1:    r_val = cs_reg.bc[7:0];
            2'd2:    r_val = cs_reg.de[15:8];
            default: r_val = cs_reg.de[7:0];
        endcase
    end
    assign inr_v = r_val + 8'd1;
    assign dcr_v = r_val - 8'd1;
    assign dad = {1'b0, cs_reg.hl} + {1'b0, pr_val};

    function automatic cpu_state_t put_pair(cpu_state_t s, logic [1:0] p, logic [15:0] v);
        cpu_state_t t;
        t = s;
        case (p)
            2'd0:    t.bc = v;
            2'd1:    t.de = v;
            default: t.hl = v;
        endcase
        return t;
    endfunction

    function automatic cpu_state_t put_reg(cpu_state_t s, logic [1:0] r, logic [7:0] v);
        cpu_state_t t;
        t = s;
        case (r)
            2'd0:    t.bc[15:8] = v;
            2'd1:    t.bc[7:0]  = v;
            2'd2:    t.de[15:8] = v;
            default: t.de[7:0]  = v;
        endcase
        return t;
    endfunction

    always_comb
    begin
        st_next = st_reg;
        cs_next = cs_reg;
        op_next = op_reg;
        lo_next = lo_reg;
        rb_next = rb_reg;
        ov_next = ov_reg;
        req.we = 1'b0;
        req.addr = cs_reg.pc;
        req.wdata = cs_reg.acc;
        if (ov_reg && m_axis_tready)
        begin
            ov_next = 1'b0;
        end
        unique case (st_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    rb_next = 8'd0;
                    if (in_mode == MODE_LOAD)
                    begin
                        req.we = 1'b1;
                        req.addr = in_addr;
                        req.wdata = in_wdata;
                        st_next = S_OUT;
                    end
                    else if (in_mode == MODE_EXEC)
                    begin
                        st_next = S_OP;
                    end
                    else if (in_mode == MODE_READ)
                    begin
                        req.addr = in_addr;
                        st_next = S_RD;
                    end
                    else
                    begin
                        st_next = S_OUT;
                    end
                end
            end
            S_RD:
            begin
                rb_next = rdata;
                st_next = S_OUT;
            end
            S_OP:
            begin
                op_next = rdata;
                st_next = S_OUT;
                cs_next.pc = pc1;
                case (rdata)
                    8'h01, 8'h11, 8'h21, 8'h06, 8'h0E, 8'h16, 8'h1E:
                    begin
                        req.addr = pc1;
                        st_next = S_LO;
                    end
                    8'h02, 8'h12, 8'h0A, 8'h1A:
                    begin
                        req.addr = rdata[4] ? cs_reg.de : cs_reg.bc;
                        req.we = ~rdata[3];
                        if (rdata[3])
                        begin
                            st_next = S_DATA;
                        end
                    end
                    default:
                    begin
                        st_next = S_DATA;
                        cs_next.pc = cs_reg.pc;
                    end
                endcase
            end
            S_LO:
            begin
                if (op_reg[2:0] == 3'd6)
                begin
                    cs_next = put_reg(cs_reg, op_reg[4:3], rdata);
                    cs_next.pc = pc1;
                    st_next = S_OUT;
                end
                else
                begin
                    lo_next = rdata;
                    cs_next.pc = pc1;
                    req.addr = pc1;
                    st_next = S_HI;
                end
            end
            S_HI:
            begin
                cs_next = put_pair(cs_reg, op_reg[5:4], {rdata, lo_reg});
                cs_next.pc = pc1;
                st_next = S_OUT;
            end
            S_DATA:
            begin
                st_next = S_OUT;
                if (op_reg == 8'h0A || op_reg == 8'h1A)
                begin
                    cs_next.acc = rdata;
                end
                else
                begin
                    cs_next.pc = pc1;
                    if (op_reg <= 8'h21)
                    begin
                        case (op_reg)
                            8'h03, 8'h13:
                                cs_next = put_pair(cs_next, op_reg[5:4], pr_val + 16'd1);
                            8'h0B, 8'h1B:
                                cs_next = put_pair(cs_next, op_reg[5:4], pr_val - 16'd1);
                            8'h04, 8'h0C, 8'h14, 8'h1C:
                            begin
                                cs_next = put_reg(cs_next, op_reg[4:3], inr_v);
                                cs_next.fz = inr_v == 8'd0;
                                cs_next.fs = inr_v[7];
                                cs_next.fp = even_par(inr_v);
                                cs_next.fa = inr_v[3:0] == 4'h0;
                            end
                            8'h05, 8'h0D, 8'h15, 8'h1D:
                            begin
                                cs_next = put_reg(cs_next, op_reg[4:3], dcr_v);
                                cs_next.fz = dcr_v == 8'd0;
                                cs_next.fs = dcr_v[7];
                                cs_next.fp = even_par(dcr_v);
                                cs_next.fa = dcr_v[3:0] != 4'hF;
                            end
                            8'h07:
                            begin
                                cs_next.fc = cs_reg.acc[7];
                                cs_next.acc = {cs_reg.acc[6:0], cs_reg.acc[7]};
                            end
                            8'h0F:
                            begin
                                cs_next.fc = cs_reg.acc[0];
                                cs_next.acc = {cs_reg.acc[0], cs_reg.acc[7:1]};
                            end
                            8'h17:
                            begin
                                cs_next.fc = cs_reg.acc[7];
                                cs_next.acc = {cs_reg.acc[6:0], cs_reg.fc};
                            end
                            8'h1F:
                            begin
                                cs_next.fc = cs_reg.acc[0];
                                cs_next.acc = {cs_reg.fc, cs_reg.acc[7:1]};
                            end
                            8'h09, 8'h19:
                            begin
                                cs_next.fc = dad[16];
                                cs_next.hl = dad[15:0];
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            S_OUT:
            begin
                ov_next = 1'b1;
                st_next = S_IDLE;
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            cs_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            cs_reg <= cs_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        lo_reg <= lo_next;
        rb_reg <= rb_next;
    end

    assign m_axis_tdata = {rb_reg, cs_reg.fc, cs_reg.fa, cs_reg.fp, cs_reg.fs, cs_reg.fz,
                           cs_reg.hl, cs_reg.de, cs_reg.bc, cs_reg.acc, cs_reg.pc};

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && !m_axis_tready |=> $stable(cs_reg))
        else $error("state changed under stalled result");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg != S_IDLE |-> !s_axis_tready)
        else $error("accept while busy");
    a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ov_reg) |-> $past(st_reg) == S_OUT)
        else $error("result raised outside finish");
endmodule
`default_nettype wire
